>>> design/prime_filter_counter_defines.svh
// ----------------------------------------------------------------------------
// prime_filter_counter assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef PRIME_FILTER_COUNTER_DEFINES_SVH
`define PRIME_FILTER_COUNTER_DEFINES_SVH

// checked only outside reset
`define PFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and microcode for the trial-division prime counter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DIV_W   = 16;
  localparam int unsigned SQ_W    = 33;
  localparam int unsigned SLOT_W  = 16;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned PC_W    = 4;

  localparam logic [DIV_W-1:0] FIRST_DIVISOR = 16'd2;
  localparam logic [SQ_W-1:0]  FIRST_SQUARE  = 33'd4;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_NOT_CAND,
    COND_SQ_GT,
    COND_DIV_BUSY,
    COND_REM_ZERO,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            load_in;
    logic            init_trial;
    logic            div_start;
    logic            next_trial;
    logic            clr_on_jump;
    logic            emit;
  } ctrl_t;

  typedef struct packed {
    logic busy;
    logic rem_zero;
  } div_status_t;

  // program steps
  localparam logic [PC_W-1:0] PC_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] PC_CHECK   = 4'd1;
  localparam logic [PC_W-1:0] PC_TESTSQ  = 4'd2;
  localparam logic [PC_W-1:0] PC_DIVGO   = 4'd3;
  localparam logic [PC_W-1:0] PC_DIVWAIT = 4'd4;
  localparam logic [PC_W-1:0] PC_TESTREM = 4'd5;
  localparam logic [PC_W-1:0] PC_STEP    = 4'd6;
  localparam logic [PC_W-1:0] PC_FINISH  = 4'd7;
  localparam logic [PC_W-1:0] PC_RETURN  = 4'd8;

  function automatic ctrl_t pfc_ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = '{cond: COND_NEVER, target: PC_WAIT, default: 1'b0};
    case (pc)
      PC_WAIT: begin
        cw.cond = COND_NO_INPUT; cw.target = PC_WAIT; cw.load_in = 1'b1;
      end
      PC_CHECK: begin
        cw.cond = COND_NOT_CAND; cw.target = PC_FINISH;
        cw.init_trial = 1'b1; cw.clr_on_jump = 1'b1;
      end
      PC_TESTSQ: begin
        cw.cond = COND_SQ_GT; cw.target = PC_FINISH;
      end
      PC_DIVGO: begin
        cw.div_start = 1'b1;
      end
      PC_DIVWAIT: begin
        cw.cond = COND_DIV_BUSY; cw.target = PC_DIVWAIT;
      end
      PC_TESTREM: begin
        cw.cond = COND_REM_ZERO; cw.target = PC_FINISH; cw.clr_on_jump = 1'b1;
      end
      PC_STEP: begin
        cw.cond = COND_ALWAYS; cw.target = PC_TESTSQ; cw.next_trial = 1'b1;
      end
      PC_FINISH: begin
        cw.cond = COND_OUT_BUSY; cw.target = PC_FINISH; cw.emit = 1'b1;
      end
      PC_RETURN: begin
        cw.cond = COND_ALWAYS; cw.target = PC_WAIT;
      end
      default: begin
        cw.cond = COND_ALWAYS; cw.target = PC_WAIT;
      end
    endcase
    return cw;
  endfunction

endpackage

>>> design/prime_filter_counter.sv
// Each word is tested by trial division; up to about 46340 trial divisors are tried, and
// values below 2 or with bit 31 set go straight to the result with no division.
// Words are handled one at a time; each trial divisor costs one pass of the shared
// remainder unit plus five microcode steps.
// The next word is taken while a finished result waits in the output register.
// rst (synchronous) clears the step counter, the prime tally and m_tvalid.
// ----------------------------------------------------------------------------
// prime_filter_counter
// Microcoded trial-division primality test with a running prime count.
// ----------------------------------------------------------------------------
module prime_filter_counter #(
  parameter int unsigned MAX_ITEMS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] value
  input  logic        s_tlast,  // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // [31:0] value_out, [47:32] prime_slot,
                                // [64:48] prime_count, [71:65] zero
  output logic        m_tuser,  // [0] is_prime
  output logic        m_tlast   // last_out
);
  import pfc_pkg::*;

  localparam logic [COUNT_W-1:0] TALLY_LIMIT =
    (MAX_ITEMS > 131071) ? 17'h1FFFF : COUNT_W'(MAX_ITEMS);
  localparam logic [COUNT_W-1:0] SLOT_MAX = COUNT_W'(16'hFFFF);

  logic [PC_W-1:0]    pc;
  logic [PC_W-1:0]    pc_next;
  ctrl_t              cw;
  logic               cond_hit;

  logic [VALUE_W-1:0] val;
  logic               lst;
  logic [DIV_W-1:0]   dvs;
  logic [SQ_W-1:0]    sq;
  logic               prime;
  logic [COUNT_W-1:0] tally;
  logic [COUNT_W-1:0] tally_next;
  logic [SLOT_W-1:0]  slot;

  div_status_t        div_st;
  logic               out_busy;
  logic               emit_now;

  pfc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cw.div_start),
    .dividend (val),
    .divisor  (dvs),
    .status   (div_st)
  );

  assign out_busy = m_tvalid & ~m_tready;

  always_comb begin
    cw = pfc_ucode(pc);
    case (cw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NO_INPUT: cond_hit = ~s_tvalid;
      COND_NOT_CAND: cond_hit = val[VALUE_W-1] | (val[VALUE_W-2:1] == '0);
      COND_SQ_GT:    cond_hit = sq > {2'b00, val[VALUE_W-2:0]};
      COND_DIV_BUSY: cond_hit = div_st.busy;
      COND_REM_ZERO: cond_hit = div_st.rem_zero;
      COND_OUT_BUSY: cond_hit = out_busy;
      default:       cond_hit = 1'b1;
    endcase
    pc_next  = cond_hit ? cw.target : pc + 1'b1;
    emit_now = cw.emit & ~cond_hit;
    s_tready = cw.load_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // trial datapath
  always_ff @(posedge clk) begin
    if (cw.load_in && s_tvalid) begin
      val <= s_tdata;
      lst <= s_tlast;
    end
    if (cw.init_trial) begin
      dvs <= FIRST_DIVISOR;
      sq  <= FIRST_SQUARE;
    end else if (cw.next_trial) begin
      dvs <= dvs + 1'b1;
      sq  <= sq + SQ_W'({dvs, 1'b1});
    end
    if (cw.clr_on_jump && cond_hit) begin
      prime <= 1'b0;
    end else if (cw.init_trial) begin
      prime <= 1'b1;
    end
  end

  // tally and slot
  always_comb begin
    tally_next = tally;
    slot       = '0;
    if (prime) begin
      slot = (tally > SLOT_MAX) ? SLOT_MAX[SLOT_W-1:0] : tally[SLOT_W-1:0];
      if (tally < TALLY_LIMIT) begin
        tally_next = tally + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (emit_now) begin
      tally <= lst ? '0 : tally_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_now) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      m_tdata <= {7'd0, tally_next, slot, val};
      m_tuser <= prime;
      m_tlast <= lst;
    end
  end

endmodule

>>> design/pfc_divider.sv
// ----------------------------------------------------------------------------
// pfc_divider
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfc_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [pfc_pkg::VALUE_W-1:0]       dividend,
  input  logic [pfc_pkg::DIV_W-1:0]         divisor,
  output pfc_pkg::div_status_t              status
);
  import pfc_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [VALUE_W-1:0] quo;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  assign trial = {rem, quo[VALUE_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(VALUE_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= diff[DIV_W-1:0];
      end else begin
        rem <= trial[DIV_W-1:0];
      end
    end
  end

  assign status.busy     = busy;
  assign status.rem_zero = (rem == '0);

endmodule

>>> design/pfc_checker.sv
// ----------------------------------------------------------------------------
// pfc_assertions
// Port-level checks on the prime counter's result stream.
// ----------------------------------------------------------------------------
`include "prime_filter_counter_defines.svh"

module pfc_assertions (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  `PFC_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "result word valid after reset")
  `PFC_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result word changed")
  `PFC_ASSERT(a_prime_range, m_tvalid && m_tuser |-> !m_tdata[31] && (m_tdata[30:1] != 30'd0), "prime flag on value below 2")
  `PFC_ASSERT(a_slot_zero, m_tvalid && !m_tuser |-> m_tdata[47:32] == 16'd0, "slot set on non-prime")
  `PFC_ASSERT(a_count_nz, m_tvalid && m_tuser |-> m_tdata[64:48] != 17'd0, "zero count on prime")

endmodule

bind prime_filter_counter pfc_assertions u_pfc_assertions (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
